[rtl/oqr_pkg.sv]
// Shared widths, command codes and the entry type of the ordered queue.
package oqr_pkg;

   localparam int ID_W     = 16;
   localparam int HANDLE_W = 32;
   localparam int OCC_W    = 5;

   localparam logic [0:0] CMD_APPEND = 1'b0;
   localparam logic [0:0] CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

[rtl/oqr_req_if.sv]
// Request channel: command, thread id and handle with valid/ready.
interface oqr_req_if import oqr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [0:0]          command;
   logic [ID_W-1:0]     thread_id;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, command, thread_id, handle, input ready);
   modport sink   (input valid, command, thread_id, handle, output ready);
endinterface

[rtl/oqr_rsp_if.sv]
// Response channel: found, handle, dropped flag and occupancy with valid/ready.
interface oqr_rsp_if import oqr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [HANDLE_W-1:0] handle_out;
   logic                dropped;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, found, handle_out, dropped, occupancy, input ready);
   modport sink   (input valid, found, handle_out, dropped, occupancy, output ready);
endinterface

[rtl/oqr_store.sv]
// Entry store: one write port and one registered read port.
module oqr_store import oqr_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/ordered_queue_remove_by_id.sv]
// Ordered thread queue with append at tail and remove of first matching id.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid/ready     command, thread_id, handle
//   rsp_chan  out   valid/ready     found, handle_out, dropped, occupancy
//
// Append, and remove from an empty queue, give their result in the cycle
// after accept. Remove scans the store one entry a cycle through its
// registered read port, then on a match closes the gap one entry a cycle.
// Reset empties the queue; store contents are left as they are. A new item
// is taken once the previous result is taken or is being taken; no item is
// taken during a scan or a shift.
module ordered_queue_remove_by_id import oqr_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   oqr_req_if.sink  req_chan,
   oqr_rsp_if.source rsp_chan
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [ADDR_W-1:0]   scan_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [ID_W-1:0]     key_ff;
   logic [HANDLE_W-1:0] hold_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic                rsp_dropped_ff;
   logic [OCC_W-1:0]    rsp_occ_ff;

   logic              accept;
   logic              full;
   logic              scan_last;
   logic              shift_last;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(DEPTH));
   assign scan_last      = ((CNT_W'(scan_ff) + CNT_W'(1)) == count_ff);
   assign shift_last     = ((CNT_W'(pos_ff) + CNT_W'(1)) == count_ff);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.handle_out = rsp_handle_ff;
   assign rsp_chan.dropped    = rsp_dropped_ff;
   assign rsp_chan.occupancy  = rsp_occ_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = rd_data;
      rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
            wr_en          = accept && (req_chan.command == CMD_APPEND) && !full;
            wr_addr        = ADDR_W'(count_ff);
            wr_data.id     = req_chan.thread_id;
            wr_data.handle = req_chan.handle;
         end
         ST_SCAN: begin
            rd_addr = scan_ff + ADDR_W'(1);
         end
         ST_SHIFT: begin
            wr_en   = !shift_last;
            rd_addr = pos_ff + ADDR_W'(2);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   oqr_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  key_ff <= req_chan.thread_id;
                  if (req_chan.command == CMD_APPEND) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_found_ff   <= 1'b0;
                     rsp_handle_ff  <= '0;
                     rsp_dropped_ff <= full;
                     if (full) begin
                        rsp_occ_ff <= OCC_W'(count_ff);
                     end else begin
                        rsp_occ_ff <= OCC_W'(count_ff + CNT_W'(1));
                        count_ff   <= count_ff + CNT_W'(1);
                     end
                  end else if (count_ff == '0) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_found_ff   <= 1'b0;
                     rsp_handle_ff  <= '0;
                     rsp_dropped_ff <= 1'b0;
                     rsp_occ_ff     <= '0;
                  end else begin
                     rsp_valid_ff <= 1'b0;
                     scan_ff      <= '0;
                     state_ff     <= ST_SCAN;
                  end
               end else if (rsp_valid_ff && rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (rd_data.id == key_ff) begin
                  hold_ff  <= rd_data.handle;
                  pos_ff   <= scan_ff;
                  state_ff <= ST_SHIFT;
               end else if (scan_last) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_found_ff   <= 1'b0;
                  rsp_handle_ff  <= '0;
                  rsp_dropped_ff <= 1'b0;
                  rsp_occ_ff     <= OCC_W'(count_ff);
                  state_ff       <= ST_IDLE;
               end else begin
                  scan_ff <= scan_ff + ADDR_W'(1);
               end
            end
            ST_SHIFT: begin
               if (shift_last) begin
                  count_ff       <= count_ff - CNT_W'(1);
                  rsp_valid_ff   <= 1'b1;
                  rsp_found_ff   <= 1'b1;
                  rsp_handle_ff  <= hold_ff;
                  rsp_dropped_ff <= 1'b0;
                  rsp_occ_ff     <= OCC_W'(count_ff - CNT_W'(1));
                  state_ff       <= ST_IDLE;
               end else begin
                  pos_ff <= pos_ff + ADDR_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
